@@ rtl/krt_pkg.sv @@
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Record layout, command and status codes, controller states and cell control.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int REC_W     = 192;

  // packed so that the identifier sits in the lowest bits
  typedef struct packed {
    logic signed [31:0] pay;
    logic        [63:0] dept;
    logic        [63:0] name;
    logic signed [31:0] id;
  } rec_t;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LIST   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_WALK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic rotate;
    logic compact;
  } cell_ctl_t;

endpackage

@@ rtl/keyed_record_table.sv @@
// ----------------------------------------------------------------------------
// keyed_record_table: insertion-ordered record table with search and delete
// Holds up to DEPTH records in a ring of cells. List, search and delete rotate
// the whole ring once past the head cell, stalling while the result side
// holds back a result; a full turn leaves the order as it was. Delete closes
// the gap in the finishing state after the turn. One item is worked on at a
// time; a finished result waits in the output register while the next item is
// taken.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [krt_pkg::REC_W-1:0] s_tdata,   // emp_id, name_tag, dept_tag, pay
  input  logic [1:0]                s_tuser,   // cmd
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [krt_pkg::REC_W-1:0] m_tdata,   // rec_id, rec_name, rec_dept, rec_pay
  output logic [1:0]                m_tuser,   // status
  output logic                      m_tlast
);
  import krt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t          state, state_next;
  cmd_t            cmd;
  rec_t            in_rec;
  logic [CNT_W-1:0] fill;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] match_idx;
  logic            found;

  rec_t            chain [DEPTH];
  rec_t            cur;
  cell_ctl_t       cell_ctl;

  logic            accept;
  logic            out_free;
  logic            want_emit;
  logic            emit;
  logic            advance;
  logic            hit;
  logic            in_range;
  logic            walk_end;
  status_t         emit_status;
  rec_t            emit_rec;
  logic            emit_last;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign cur      = chain[0];
  assign in_range = CNT_W'(step) < fill;
  assign walk_end = step == IDX_W'(DEPTH - 1);

  // ring of cells, each takes the next one's record on rotate
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam int NXT = (k + 1) % DEPTH;
    krt_cell #(
      .DEPTH (DEPTH),
      .IDX   (k)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .fill      (fill),
      .match_idx (match_idx),
      .load_rec  (in_rec),
      .nbr       (chain[NXT]),
      .rec       (chain[k])
    );
  end

  // output and cell control
  always_comb begin
    s_tready    = 1'b0;
    want_emit   = 1'b0;
    hit         = 1'b0;
    emit_status = ST_OK;
    emit_rec    = '0;
    emit_last   = 1'b1;
    cell_ctl    = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_ADD: begin
        want_emit = 1'b1;
        if (fill == CNT_W'(DEPTH)) begin
          emit_status = ST_FULL;
        end else begin
          emit_rec      = in_rec;
          cell_ctl.load = out_free;
        end
      end
      S_WALK: begin
        if (cmd == CMD_LIST) begin
          if (fill == '0) begin
            want_emit   = step == '0;
            emit_status = ST_EMPTY;
          end else begin
            want_emit = in_range;
            emit_rec  = cur;
            emit_last = (CNT_W'(step) + CNT_W'(1)) == fill;
          end
        end else begin
          hit       = in_range && !found && (cur.id == in_rec.id);
          want_emit = hit;
          emit_rec  = cur;
        end
        cell_ctl.rotate = !want_emit || out_free;
      end
      S_FIN: begin
        if (cmd != CMD_LIST) begin
          if (!found) begin
            want_emit   = 1'b1;
            emit_status = ST_NOT_FOUND;
          end else if (cmd == CMD_DELETE) begin
            cell_ctl.compact = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    emit    = want_emit && out_free;
    advance = !want_emit || out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(s_tuser) == CMD_ADD) ? S_ADD : S_WALK;
        end
      end
      S_ADD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (advance && walk_end) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (advance) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      found    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        found <= 1'b0;
      end else if (hit && advance) begin
        found <= 1'b1;
      end
      if (cell_ctl.load) begin
        fill <= fill + CNT_W'(1);
      end else if (cell_ctl.compact) begin
        fill <= fill - CNT_W'(1);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= cmd_t'(s_tuser);
      in_rec <= rec_t'(s_tdata);
      step   <= '0;
    end else if (state == S_WALK && advance) begin
      step <= step + IDX_W'(1);
    end
    if (hit && advance) begin
      match_idx <= step;
    end
    if (emit) begin
      m_tdata <= emit_rec;
      m_tuser <= emit_status;
      m_tlast <= emit_last;
    end
  end

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("record count beyond table depth");

  a_ctl_excl : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cell_ctl.load, cell_ctl.rotate, cell_ctl.compact}))
    else $error("cells given more than one operation");

  a_load_room : assert property (@(posedge clk) disable iff (rst)
    cell_ctl.load |-> (fill < CNT_W'(DEPTH)))
    else $error("record loaded into a full table");

  a_compact_count : assert property (@(posedge clk) disable iff (rst)
    cell_ctl.compact |=> (fill == $past(fill) - CNT_W'(1)))
    else $error("delete did not drop the record count");

endmodule

@@ rtl/krt_cell.sv @@
// ----------------------------------------------------------------------------
// krt_cell: one record slot of the table chain
// Loads a new record, takes its neighbor's record on rotate, or on compact
// closes the gap left by a removed record.
// ----------------------------------------------------------------------------
module krt_cell #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  krt_pkg::cell_ctl_t                    ctl,
  input  logic [$clog2(DEPTH+1)-1:0]            fill,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] match_idx,
  input  krt_pkg::rec_t                         load_rec,
  input  krt_pkg::rec_t                         nbr,
  output krt_pkg::rec_t                         rec
);
  import krt_pkg::*;

  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam bit LAST_CELL = (IDX == DEPTH - 1);

  logic load_here;
  logic shift_down;

  assign load_here  = ctl.load && (fill == CNT_W'(IDX));
  // cells at and above the removed slot take the next record; the end holds
  assign shift_down = ctl.compact && (IDX_W'(IDX) >= match_idx) && !LAST_CELL;

  always_ff @(posedge clk) begin
    if (load_here) begin
      rec <= load_rec;
    end else if (ctl.rotate || shift_down) begin
      rec <= nbr;
    end
  end

endmodule

@@ sim/krt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_checker: result predictor and comparator for keyed_record_table
// Watches both stream channels, keeps a shadow copy of the record table,
// works out the results of every accepted command and compares each returned
// item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module krt_checker #(
  parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [krt_pkg::REC_W-1:0] s_tdata,   // emp_id, name_tag, dept_tag, pay
  input  logic [1:0]                s_tuser,   // cmd
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [krt_pkg::REC_W-1:0] m_tdata,   // rec_id, rec_name, rec_dept, rec_pay
  input  logic [1:0]                m_tuser,   // status
  input  logic                      m_tlast,
  output int unsigned               errors,
  output int unsigned               pending,
  output int unsigned               results_seen,
  output int unsigned               full_seen
);
  import krt_pkg::*;

  typedef struct packed {
    status_t st;
    rec_t    rec;
    logic    last;
  } table_result_t;

  rec_t          shadow_rows [DEPTH];
  int            row_count;
  table_result_t expected_results [$];

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
    full_seen    = 0;
    row_count    = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 40)
      $display("[%0t] result %0d: %s got %h, expected %h",
               $time, results_seen, what, got, want);
    errors++;
  endtask

  function automatic void queue_result(input status_t st, input rec_t rec,
                                       input logic last);
    table_result_t r;
    r.st   = st;
    r.rec  = rec;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_item(input cmd_t op, input rec_t item);
    int hit;
    hit = -1;
    case (op)
      CMD_ADD: begin
        if (row_count >= DEPTH) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          shadow_rows[row_count] = item;
          row_count++;
          queue_result(ST_OK, item, 1'b1);
        end
      end
      CMD_LIST: begin
        if (row_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < row_count; i++)
            queue_result(ST_OK, shadow_rows[i], i == row_count - 1);
        end
      end
      default: begin
        // search and delete act on the earliest matching key
        for (int i = 0; i < row_count; i++)
          if (hit < 0 && shadow_rows[i].id == item.id) hit = i;
        if (hit < 0) begin
          queue_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          queue_result(ST_OK, shadow_rows[hit], 1'b1);
          if (op == CMD_DELETE) begin
            for (int i = hit; i + 1 < row_count; i++)
              shadow_rows[i] = shadow_rows[i + 1];
            row_count--;
          end
        end
      end
    endcase
  endfunction

  task automatic check_result(input status_t st, input rec_t rec, input logic last);
    table_result_t want;
    results_seen++;
    if (st == ST_FULL) full_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending, status", st, '0);
    end else begin
      want = expected_results.pop_front();
      if (st !== want.st)             report_mismatch("status", st, want.st);
      if (rec.id !== want.rec.id)     report_mismatch("rec_id", rec.id, want.rec.id);
      if (rec.name !== want.rec.name) report_mismatch("rec_name", rec.name, want.rec.name);
      if (rec.dept !== want.rec.dept) report_mismatch("rec_dept", rec.dept, want.rec.dept);
      if (rec.pay !== want.rec.pay)   report_mismatch("rec_pay", rec.pay, want.rec.pay);
      if (last !== want.last)         report_mismatch("last", last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_results.delete();
      row_count = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result(status_t'(m_tuser), rec_t'(m_tdata), m_tlast);
      if (s_tvalid && s_tready) predict_item(cmd_t'(s_tuser), rec_t'(s_tdata));
      pending <= expected_results.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for keyed_record_table
// Drives a directed command sequence and then random add, list, search and
// delete traffic, including a fill past capacity, under changing source and
// sink idle patterns; the checker instance does all prediction and compare.
// ----------------------------------------------------------------------------
module testbench;
  import krt_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int KEYS  = 8;

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  rec_t             s_tdata  = '0;
  cmd_t             s_tuser  = CMD_ADD;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [REC_W-1:0] m_tdata;
  logic [1:0]       m_tuser;
  logic             m_tlast;

  int unsigned      errors;
  int unsigned      pending;
  int unsigned      results_seen;
  int unsigned      full_seen;

  int               src_idle_pct  = 0;
  int               snk_stall_pct = 0;
  int               items_sent    = 0;
  logic signed [31:0] key_pool [KEYS];

  keyed_record_table #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  krt_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .errors       (errors),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // valid is only lowered when an idle gap is taken, so back-to-back items
  // never see two assignments to it in one step
  task automatic send_item(input cmd_t op, input logic signed [31:0] key,
                           input logic [63:0] name, input logic [63:0] dept,
                           input logic signed [31:0] pay);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {pay, dept, name, key};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic send_random(input int add_w, input int list_w, input int search_w);
    int                 roll;
    cmd_t               op;
    logic signed [31:0] key;
    roll = $urandom_range(99);
    if (roll < add_w)                          op = CMD_ADD;
    else if (roll < add_w + list_w)            op = CMD_LIST;
    else if (roll < add_w + list_w + search_w) op = CMD_SEARCH;
    else                                       op = CMD_DELETE;
    // mostly reuse a few keys so that search and delete hit, and duplicates occur
    if ($urandom_range(9) < 8) key = key_pool[$urandom_range(KEYS - 1)];
    else                       key = $urandom;
    send_item(op, key, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sd0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < KEYS; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table cases
    send_item(CMD_LIST,   32'sd0, '0, '0, 32'sd0);
    send_item(CMD_SEARCH, 32'sd0, '1, '1, -32'sd1);
    send_item(CMD_DELETE, -32'sd1, '0, '0, 32'sd0);
    // field extremes and duplicate keys
    send_item(CMD_ADD, 32'sh8000_0000, 64'h0, 64'hffff_ffff_ffff_ffff, 32'sh7fff_ffff);
    send_item(CMD_ADD, 32'sh7fff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0, 32'sh8000_0000);
    send_item(CMD_ADD, 32'sd0, 64'h4164_616d_536d_6974, 64'h5361_6c65_7300_0000, 32'sd0);
    send_item(CMD_ADD, 32'sd5, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 32'sd1);
    send_item(CMD_ADD, 32'sd5, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 32'sd2);
    send_item(CMD_LIST,   32'sd0, '0, '0, 32'sd0);
    send_item(CMD_SEARCH, 32'sd5, '0, '0, 32'sd0);
    send_item(CMD_SEARCH, 32'sh7fff_ffff, '0, '0, 32'sd0);
    send_item(CMD_SEARCH, 32'sd7, '0, '0, 32'sd0);
    send_item(CMD_DELETE, 32'sd5, '0, '0, 32'sd0);
    send_item(CMD_SEARCH, 32'sd5, '0, '0, 32'sd0);
    send_item(CMD_DELETE, 32'sh8000_0000, '0, '0, 32'sd0);
    send_item(CMD_DELETE, 32'sd0, '0, '0, 32'sd0);
    send_item(CMD_LIST,   32'sd0, '0, '0, 32'sd0);
    send_item(CMD_DELETE, 32'sd5, '0, '0, 32'sd0);
    send_item(CMD_DELETE, 32'sh7fff_ffff, '0, '0, 32'sd0);
    send_item(CMD_LIST,   32'sd0, '0, '0, 32'sd0);
    send_item(CMD_DELETE, -32'sd1, '0, '0, 32'sd0);
    // hold the source until every result of the directed part is back
    wait_drained();

    repeat (80) send_random(40, 8, 25);
    wait_drained();

    src_idle_pct = 62;
    repeat (80) send_random(40, 8, 25);
    wait_drained();

    // fill past capacity, list a full table, then send mostly deletes with some adds, lists and searches
    src_idle_pct  = 0;
    snk_stall_pct = 62;
    repeat (70) send_random(100, 0, 0);
    send_item(CMD_LIST, 32'sd0, '0, '0, 32'sd0);
    repeat (39) send_random(15, 5, 20);

    src_idle_pct  = 21;
    snk_stall_pct = 21;
    repeat (40) send_random(40, 8, 25);
    wait_drained();

    repeat (DEPTH + 16) @(posedge clk);
    $display("ran %0d commands and checked %0d result items", items_sent, results_seen);
    $display("%0d adds were refused on a full table", full_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d result items outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
